// ----- design/artbl_pkg.sv -----
// Shared constants, codes and types of the ARP reply learning table.
package artbl_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // ARP operation code of a reply.
  localparam logic [15:0] ARP_REPLY = 16'd2;

  // Item kinds.
  localparam logic [1:0] KIND_FRAME   = 2'd0;
  localparam logic [1:0] KIND_NEXT    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_ADDED   = 3'd1;
  localparam logic [2:0] ST_UPDATED = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ENTRY   = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  // Write request from the sequencer to the slot store.
  typedef struct packed {
    logic             en;
    logic             add;
    logic [IDX_W-1:0] idx;
    logic [31:0]      ip;
    logic [47:0]      mac;
  } wr_req_t;

  // Results of the shared comparator.
  typedef struct packed {
    logic eq_key;
    logic gt_last;
    logic lt_best;
  } cmp_res_t;

endpackage

// ----- design/artbl_store.sv -----
// Slot store: IP and MAC memories with registered read, and the valid flags.
module artbl_store
  import artbl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [IDX_W-1:0]         rd_addr,
  output logic [31:0]              rd_ip,
  output logic [47:0]              rd_mac,
  input  wr_req_t                  wr,
  output logic [TABLE_ENTRIES-1:0] valid
);

  logic [31:0]              ip_mem  [TABLE_ENTRIES];
  logic [47:0]              mac_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] valid_nxt;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mac_mem[wr.idx] <= wr.mac;
      if (wr.add) begin
        ip_mem[wr.idx] <= wr.ip;
      end
    end
    rd_ip  <= ip_mem[rd_addr];
    rd_mac <= mac_mem[rd_addr];
  end

  // A slot becomes valid when a new IP is added to it.
  always_comb begin
    valid_nxt = valid_r;
    if (wr.en && wr.add) begin
      valid_nxt[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign valid = valid_r;

endmodule

// ----- design/artbl_cmp.sv -----
// Shared comparator applied to the slot read out in each scan cycle.
module artbl_cmp
  import artbl_pkg::*;
(
  input  logic [31:0] slot_ip,
  input  logic [31:0] key_ip,
  input  logic [31:0] last_ip,
  input  logic [31:0] best_ip,
  output cmp_res_t    res
);

  // Equality for learning, ordering for the sorted readout.
  always_comb begin
    res.eq_key  = (slot_ip == key_ip);
    res.gt_last = (slot_ip > last_ip);
    res.lt_best = (slot_ip < best_ip);
  end

endmodule

// ----- design/arp_reply_learning_table_unit.sv -----
// Top level: sequencer of the ARP reply learning table with its output register.
//
//  Channel  | Ports                                          | Handshake
//  ---------+------------------------------------------------+------------------
//  input    | in_kind in_opcode in_target_ip in_sender_ip/mac | in_valid/in_ready
//  result   | out_status out_entry_ip out_entry_mac           | out_valid/out_ready
//  config   | cfg_wdata (own IP)                             | cfg_we, no wait
//
// A learned frame or a read-next item scans every slot through the one memory
// read port and the shared comparator, then passes the commit state (S_COMMIT)
// before its result is loaded in S_FIN. Ignored frames and restart items go from
// idle straight to S_FIN. Reset clears the valid flags at once; no clearing pass.
// The block takes one item at a time and holds a finished result until the
// output register is free, so a stalled output stalls the input.
module arp_reply_learning_table_unit
  import artbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_opcode,
  input  logic [31:0] in_target_ip,
  input  logic [31:0] in_sender_ip,
  input  logic [47:0] in_sender_mac,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_entry_ip,
  output logic [47:0] out_entry_mac,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_FIN    = 2'd3;

  // Control state.
  logic [1:0]       state_r, state_nxt;
  logic             op_read_r, op_read_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             match_r, match_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             best_r, best_nxt;
  logic             started_r, started_nxt;
  logic [31:0]      last_ip_r, last_ip_nxt;
  logic [31:0]      own_ip_r;
  logic             out_valid_r, out_valid_nxt;

  // Payload state.
  logic [31:0] key_ip_r, key_ip_nxt;
  logic [47:0] key_mac_r, key_mac_nxt;
  logic [31:0] best_ip_r, best_ip_nxt;
  logic [47:0] best_mac_r, best_mac_nxt;
  logic [2:0]  res_status_r, res_status_nxt;
  logic [31:0] res_ip_r, res_ip_nxt;
  logic [47:0] res_mac_r, res_mac_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [31:0] out_ip_r, out_ip_nxt;
  logic [47:0] out_mac_r, out_mac_nxt;

  logic [31:0]              rd_ip;
  logic [47:0]              rd_mac;
  logic [TABLE_ENTRIES-1:0] slot_vld;
  wr_req_t                  wr;
  cmp_res_t                 cmp;
  logic                     chk_slot_vld;

  artbl_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_ip   (rd_ip),
    .rd_mac  (rd_mac),
    .wr      (wr),
    .valid   (slot_vld)
  );

  artbl_cmp u_cmp (
    .slot_ip (rd_ip),
    .key_ip  (key_ip_r),
    .last_ip (last_ip_r),
    .best_ip (best_ip_r),
    .res     (cmp)
  );

  assign chk_slot_vld = slot_vld[chk_idx_r];
  assign in_ready     = (state_r == S_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    op_read_nxt    = op_read_r;
    idx_nxt        = idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    match_nxt      = match_r;
    match_idx_nxt  = match_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    best_nxt       = best_r;
    started_nxt    = started_r;
    last_ip_nxt    = last_ip_r;
    key_ip_nxt     = key_ip_r;
    key_mac_nxt    = key_mac_r;
    best_ip_nxt    = best_ip_r;
    best_mac_nxt   = best_mac_r;
    res_status_nxt = res_status_r;
    res_ip_nxt     = res_ip_r;
    res_mac_nxt    = res_mac_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_ip_nxt     = out_ip_r;
    out_mac_nxt    = out_mac_r;
    wr             = '0;
    wr.idx         = match_idx_r;
    wr.ip          = key_ip_r;
    wr.mac         = key_mac_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_ip_nxt     = in_sender_ip;
          key_mac_nxt    = in_sender_mac;
          idx_nxt        = '0;
          match_nxt      = 1'b0;
          free_nxt       = 1'b0;
          best_nxt       = 1'b0;
          res_status_nxt = ST_IGNORED;
          res_ip_nxt     = '0;
          res_mac_nxt    = '0;
          state_nxt      = S_FIN;
          unique case (in_kind)
            KIND_FRAME: begin
              if (in_opcode == ARP_REPLY && in_target_ip == own_ip_r) begin
                op_read_nxt = 1'b0;
                state_nxt   = S_SCAN;
              end
            end
            KIND_NEXT: begin
              op_read_nxt = 1'b1;
              state_nxt   = S_SCAN;
            end
            KIND_RESTART: begin
              started_nxt = 1'b0;
              last_ip_nxt = '0;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next slot address; the data comes back in the next cycle.
        if (idx_r < CNT_W'(TABLE_ENTRIES)) begin
          idx_nxt     = idx_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r[IDX_W-1:0];
        end
        // Examine the slot read in the previous cycle.
        if (chk_vld_r) begin
          if (op_read_r) begin
            if (chk_slot_vld && (!started_r || cmp.gt_last) && (!best_r || cmp.lt_best)) begin
              best_nxt     = 1'b1;
              best_ip_nxt  = rd_ip;
              best_mac_nxt = rd_mac;
            end
          end else begin
            if (chk_slot_vld && cmp.eq_key) begin
              match_nxt     = 1'b1;
              match_idx_nxt = chk_idx_r;
            end
            if (!chk_slot_vld && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = chk_idx_r;
            end
          end
          if (chk_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
            state_nxt = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        state_nxt = S_FIN;
        if (op_read_r) begin
          if (best_r) begin
            started_nxt    = 1'b1;
            last_ip_nxt    = best_ip_r;
            res_status_nxt = ST_ENTRY;
            res_ip_nxt     = best_ip_r;
            res_mac_nxt    = best_mac_r;
          end else begin
            res_status_nxt = ST_DONE;
          end
        end else begin
          res_ip_nxt  = key_ip_r;
          res_mac_nxt = key_mac_r;
          if (match_r) begin
            wr.en          = 1'b1;
            res_status_nxt = ST_UPDATED;
          end else if (free_r) begin
            wr.en          = 1'b1;
            wr.add         = 1'b1;
            wr.idx         = free_idx_r;
            res_status_nxt = ST_ADDED;
          end else begin
            res_status_nxt = ST_FULL;
          end
        end
      end

      S_FIN: begin
        // Load the result once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ip_nxt     = res_ip_r;
          out_mac_nxt    = res_mac_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_read_r   <= 1'b0;
      idx_r       <= '0;
      chk_vld_r   <= 1'b0;
      chk_idx_r   <= '0;
      match_r     <= 1'b0;
      match_idx_r <= '0;
      free_r      <= 1'b0;
      free_idx_r  <= '0;
      best_r      <= 1'b0;
      started_r   <= 1'b0;
      last_ip_r   <= '0;
      own_ip_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_read_r   <= op_read_nxt;
      idx_r       <= idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      chk_idx_r   <= chk_idx_nxt;
      match_r     <= match_nxt;
      match_idx_r <= match_idx_nxt;
      free_r      <= free_nxt;
      free_idx_r  <= free_idx_nxt;
      best_r      <= best_nxt;
      started_r   <= started_nxt;
      last_ip_r   <= last_ip_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        own_ip_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_ip_r     <= key_ip_nxt;
    key_mac_r    <= key_mac_nxt;
    best_ip_r    <= best_ip_nxt;
    best_mac_r   <= best_mac_nxt;
    res_status_r <= res_status_nxt;
    res_ip_r     <= res_ip_nxt;
    res_mac_r    <= res_mac_nxt;
    out_status_r <= out_status_nxt;
    out_ip_r     <= out_ip_nxt;
    out_mac_r    <= out_mac_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_entry_ip  = out_ip_r;
  assign out_entry_mac = out_mac_r;

endmodule

// ----- design/artbl_checker.sv -----
// Port-level checker of the ARP reply learning table, bound to the top level.
module artbl_checker
  import artbl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_entry_ip,
  input logic [47:0] out_entry_mac
);

  // A result waiting for the consumer is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // One item at a time: the block is busy right after accepting an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted item");

  // Only defined status codes are ever reported.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_DONE))
    else $error("undefined status code");

  // Ignored items and an exhausted readout carry no entry.
  a_empty_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_IGNORED || out_status == ST_DONE)
      |-> (out_entry_ip == '0 && out_entry_mac == '0))
    else $error("entry fields not cleared");

endmodule

bind arp_reply_learning_table_unit artbl_checker u_artbl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_entry_ip  (out_entry_ip),
  .out_entry_mac (out_entry_mac)
);
